@@ rtl/core/ctp_pkg.sv @@
// Shared types for the cycle trace profiler: opcodes, controller states and
// the packed layout of one statistics record. No dependencies.
package ctp_pkg;

  localparam int unsigned TAG_SLOTS = 4;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned STAT_W    = 64;
  localparam int unsigned DEPTH_W   = 8;
  localparam int unsigned ID_W      = 16;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_WORK  = 2'd2
  } state_t;

  typedef logic [TAG_SLOTS-1:0][TAG_W-1:0] tags_t;

  typedef struct packed {
    logic [STAT_W-1:0]  start_stamp;
    logic [STAT_W-1:0]  sum_cycles;
    logic [STAT_W-1:0]  least_cycles;
    logic [STAT_W-1:0]  most_cycles;
    logic [STAT_W-1:0]  finish_count;
    logic [DEPTH_W-1:0] nest_depth;
    tags_t              path_tags;
  } rec_t;

  localparam rec_t REC_RESET = '{
    start_stamp:  '0,
    sum_cycles:   '0,
    least_cycles: '0,
    most_cycles:  '0,
    finish_count: '0,
    nest_depth:   '0,
    path_tags:    '1
  };

endpackage

@@ rtl/core/cycle_trace_profiler.sv @@
// Cycle trace profiler top level: record memory, clear sweep, read-modify-write
// controller and result register. Depends on ctp_pkg.
//
// The block keeps one statistics record per region id in a single synchronous
// memory (NUM_RECORDS entries, one read and one write port, registered read).
// After reset it sweeps the memory once, one record per cycle, and takes no
// word until the sweep is done; every record then holds zero stamps and counts
// and all path tags at minus one. A start word stamps cycle_now, depth and the
// first PATH_LEVELS path tags into its record; an end word measures elapsed
// time from the stored stamp and folds it into total, minimum, maximum and
// count; a read word (opcode two or three) reports the record as it stands.
// Every word gives exactly one result showing the record after the step. An id
// that is negative or not below NUM_RECORDS touches no record, bumps the
// invalid counter and returns status one with all record fields zero. For each
// word the accept edge issues the memory read; write-back of the updated record
// and loading of the result register wait until that register can take the
// word. The input side accepts again right after write-back, even while the
// previous result still waits in the output register, so a new read always
// sees the prior write and no forwarding is needed.
module cycle_trace_profiler
  import ctp_pkg::*;
#(
  parameter int unsigned NUM_RECORDS = 256,
  parameter int unsigned PATH_LEVELS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                opcode,
  input  logic signed [ID_W-1:0]    record_id,
  input  logic [DEPTH_W-1:0]        depth,
  input  logic signed [TAG_W-1:0]   path_a,
  input  logic signed [TAG_W-1:0]   path_b,
  input  logic signed [TAG_W-1:0]   path_c,
  input  logic signed [TAG_W-1:0]   path_d,
  input  logic [STAT_W-1:0]         cycle_now,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      status,
  output logic [STAT_W-1:0]         elapsed,
  output logic [STAT_W-1:0]         hit_count,
  output logic [STAT_W-1:0]         total_cycles,
  output logic [STAT_W-1:0]         min_cycles,
  output logic [STAT_W-1:0]         max_cycles,
  output logic [DEPTH_W-1:0]        depth_out,
  output logic signed [TAG_W-1:0]   path_a_out,
  output logic signed [TAG_W-1:0]   path_b_out,
  output logic signed [TAG_W-1:0]   path_c_out,
  output logic signed [TAG_W-1:0]   path_d_out,
  output logic [STAT_W-1:0]         invalid_total
);

  localparam int unsigned IDX_W = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
  localparam logic [ID_W:0] NUM_REC_W = (ID_W+1)'(NUM_RECORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RECORDS - 1);

  // Record memory, written and read in clocked blocks.
  rec_t mem [NUM_RECORDS];

  state_t state, state_next;
  logic [IDX_W-1:0] clr_idx;

  // Captured word.
  op_t               op_q;
  logic              bad_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DEPTH_W-1:0] depth_q;
  tags_t             tags_q;
  logic [STAT_W-1:0] now_q;
  rec_t              rd;

  logic [STAT_W-1:0] bad_count;

  logic              accept;
  logic              finish;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  rec_t              wr_data;
  rec_t              rec_new;
  logic [STAT_W-1:0] elapsed_now;
  logic              id_ok;

  // Range check: negative ids fail on the sign bit, the rest on the bound.
  assign id_ok  = !record_id[ID_W-1] && ({1'b0, $unsigned(record_id)} < NUM_REC_W);
  assign accept = in_valid && in_ready;

  // Controller: clear sweep, then alternate between accepting and updating.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        // Hold until the result register can take the word.
        finish = !out_valid || out_ready;
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Capture the word and issue the memory read on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= (opcode == OP_START) ? OP_START :
                 (opcode == OP_END)   ? OP_END   : OP_READ;
      bad_q   <= !id_ok;
      idx_q   <= record_id[IDX_W-1:0];
      depth_q <= depth;
      tags_q  <= {path_d, path_c, path_b, path_a};
      now_q   <= cycle_now;
      rd      <= mem[record_id[IDX_W-1:0]];
    end
  end

  // Update the record as read back.
  assign elapsed_now = now_q - rd.start_stamp;

  always_comb begin
    rec_new = rd;
    unique case (op_q)
      OP_START: begin
        rec_new.start_stamp = now_q;
        rec_new.nest_depth  = depth_q;
        for (int t = 0; t < TAG_SLOTS; t++) begin
          if (t < PATH_LEVELS) begin
            rec_new.path_tags[t] = tags_q[t];
          end
        end
      end
      OP_END: begin
        rec_new.sum_cycles   = rd.sum_cycles + elapsed_now;
        if ((rd.finish_count == '0) || (elapsed_now < rd.least_cycles)) begin
          rec_new.least_cycles = elapsed_now;
        end
        if (elapsed_now > rd.most_cycles) begin
          rec_new.most_cycles = elapsed_now;
        end
        rec_new.finish_count = rd.finish_count + 1'b1;
      end
      default: begin
        rec_new = rd;
      end
    endcase
  end

  // Single write port: clear sweep or write-back of a valid word.
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_idx  = clr_idx;
      wr_data = REC_RESET;
    end else begin
      wr_en   = finish && !bad_q;
      wr_idx  = idx_q;
      wr_data = rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Invalid-id counter advances as the failing word completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_count <= '0;
    end else if (finish && bad_q) begin
      bad_count <= bad_count + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (bad_q) begin
        status        <= 1'b1;
        elapsed       <= '0;
        hit_count     <= '0;
        total_cycles  <= '0;
        min_cycles    <= '0;
        max_cycles    <= '0;
        depth_out     <= '0;
        path_a_out    <= '0;
        path_b_out    <= '0;
        path_c_out    <= '0;
        path_d_out    <= '0;
        invalid_total <= bad_count + 1'b1;
      end else begin
        status        <= 1'b0;
        elapsed       <= (op_q == OP_END) ? elapsed_now : '0;
        hit_count     <= rec_new.finish_count;
        total_cycles  <= rec_new.sum_cycles;
        min_cycles    <= rec_new.least_cycles;
        max_cycles    <= rec_new.most_cycles;
        depth_out     <= rec_new.nest_depth;
        path_a_out    <= rec_new.path_tags[0];
        path_b_out    <= rec_new.path_tags[1];
        path_c_out    <= rec_new.path_tags[2];
        path_d_out    <= rec_new.path_tags[3];
        invalid_total <= bad_count;
      end
    end
  end

endmodule
